### rtl/cqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cqs_pkg;

    localparam int CAP_W   = 7;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 6;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    typedef struct packed {
        t_action                   action;
        logic signed [WORD_W-1:0]  value;
    } t_req;

    typedef struct packed {
        t_status                   status;
        logic signed [WORD_W-1:0]  data;
        logic [POS_W-1:0]          position;
    } t_res;

    typedef struct packed {
        logic                load;
        logic                adv;
        logic [WORD_W-1:0]   wdata;
        logic [WORD_W-1:0]   key;
    } t_cell_bus;

    typedef struct packed {
        logic wr;
        logic head;
        logic last;
    } t_cell_sel;

endpackage

`default_nettype wire

### rtl/cqs_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module cqs_cell
    import cqs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cell_bus          i_bus,
    input  wire t_cell_sel          i_sel,
    input  wire logic               i_tok,
    output logic                    o_tok_fwd,
    output logic                    o_tok_wrap,
    output logic                    o_hit,
    output logic [WORD_W-1:0]       o_rdata
);

    logic [WORD_W-1:0] r_word;
    logic              r_tok;

    always_ff @(posedge i_clk) begin
        if (i_sel.wr) begin
            r_word <= i_bus.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else if (i_bus.load) begin
            r_tok <= i_sel.head;
        end else if (i_bus.adv) begin
            r_tok <= i_tok;
        end
    end

    assign o_tok_fwd  = r_tok & ~i_sel.last;
    assign o_tok_wrap = r_tok & i_sel.last;
    assign o_hit      = r_tok & (r_word == i_bus.key);
    assign o_rdata    = i_sel.head ? r_word : '0;

endmodule

`default_nettype wire

### rtl/circular_queue_with_search.sv
`timescale 1ns / 1ps
`default_nettype none

// Circular FIFO of signed 32-bit words built as a row of DEPTH cells, each
// holding one slot. Insert, delete, an unused action and a search on an empty
// queue answer without a token walk: the result strobe rises on the next clock
// and busy stays low. A search loads a token into the head cell and passes it
// one cell per clock toward the tail, wrapping at the last slot of the
// capacity; busy is high while the token walks, and the search ends on the
// first occupied slot holding the key, or with not-found once every occupied
// slot has been passed. The result is shown for a single cycle and cannot be
// held off by the receiver. Writing the capacity register empties the queue.
module circular_queue_with_search
    import cqs_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_req               i_req,
    output logic                    o_res_valid,
    output t_res                    o_res,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CAP_W-1:0]   i_cfg_data
);

    localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CXW = (CW > CAP_W) ? CW : CAP_W;

    t_state            r_state, n_state;
    logic [CAP_W-1:0]  r_cap;
    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_tail, n_tail;
    logic [CW-1:0]     r_occ, n_occ;
    logic [IW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [WORD_W-1:0] r_key, n_key;
    logic              r_res_valid, n_res_valid;
    t_res              r_res, n_res;

    logic [CXW-1:0]    cap_x;
    logic [CW-1:0]     cap_eff;
    logic [IW-1:0]     last_idx;
    logic              accept;
    logic              cfg_wr;
    logic              full;
    t_cell_bus         bus;
    t_cell_sel         sel    [DEPTH];
    logic [DEPTH-1:0]  tok_in;
    logic [DEPTH-1:0]  tok_fwd;
    logic [DEPTH-1:0]  tok_wrap;
    logic [DEPTH-1:0]  hit_vec;
    logic [WORD_W-1:0] rdata  [DEPTH];
    logic [WORD_W-1:0] rd_or;
    logic              hit;

    assign cap_x = CXW'(r_cap);

    always_comb begin
        if (cap_x == '0) begin
            cap_eff = CW'(1);
        end else if (cap_x > CXW'(DEPTH)) begin
            cap_eff = CW'(DEPTH);
        end else begin
            cap_eff = CW'(cap_x);
        end
    end

    assign last_idx    = IW'(cap_eff - CW'(1));
    assign busy        = (r_state == ST_SEARCH);
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign full        = (r_occ >= cap_eff);

    always_comb begin
        rd_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_or = rd_or | rdata[k];
        end
    end

    assign hit = |hit_vec;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            assign sel[g].wr   = accept && (i_req.action == ACT_INSERT) && !full
                                 && (r_tail == IW'(g));
            assign sel[g].head = (r_head == IW'(g));
            assign sel[g].last = (last_idx == IW'(g));
            if (g == 0) begin : g_first
                assign tok_in[g] = (|tok_wrap) | tok_fwd[DEPTH-1];
            end else begin : g_rest
                assign tok_in[g] = tok_fwd[g-1];
            end
            cqs_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_bus      (bus),
                .i_sel      (sel[g]),
                .i_tok      (tok_in[g]),
                .o_tok_fwd  (tok_fwd[g]),
                .o_tok_wrap (tok_wrap[g]),
                .o_hit      (hit_vec[g]),
                .o_rdata    (rdata[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            if (cfg_wr) begin
                r_cap  <= i_cfg_data;
                r_head <= '0;
                r_tail <= '0;
                r_occ  <= '0;
            end else begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_occ  <= n_occ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_cnt <= n_cnt;
        r_key <= n_key;
        r_res <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_key       = r_key;
        n_res_valid = 1'b0;
        n_res       = r_res;
        bus.load    = 1'b0;
        bus.adv     = 1'b0;
        bus.wdata   = i_req.value;
        bus.key     = r_key;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res_valid     = 1'b1;
                    n_res.status    = STAT_OK;
                    n_res.data      = '0;
                    n_res.position  = '0;
                    case (i_req.action)
                        ACT_INSERT: begin
                            if (full) begin
                                n_res.status = STAT_FULL;
                            end else begin
                                n_tail = (r_tail == last_idx) ? '0 : IW'(r_tail + 1'b1);
                                n_occ  = CW'(r_occ + 1'b1);
                            end
                        end
                        ACT_DELETE: begin
                            if (r_occ == '0) begin
                                n_res.status = STAT_EMPTY;
                            end else begin
                                n_res.data = rd_or;
                                n_head = (r_head == last_idx) ? '0 : IW'(r_head + 1'b1);
                                n_occ  = CW'(r_occ - 1'b1);
                            end
                        end
                        ACT_SEARCH: begin
                            if (r_occ == '0) begin
                                n_res.status = STAT_EMPTY;
                            end else begin
                                n_res_valid = 1'b0;
                                bus.load    = 1'b1;
                                n_key       = i_req.value;
                                n_idx       = r_head;
                                n_cnt       = '0;
                                n_state     = ST_SEARCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    n_res_valid    = 1'b1;
                    n_res.status   = STAT_OK;
                    n_res.data     = '0;
                    n_res.position = POS_W'(r_idx);
                    n_state        = ST_IDLE;
                end else if (r_cnt == CW'(r_occ - 1'b1)) begin
                    n_res_valid    = 1'b1;
                    n_res.status   = STAT_NOTFOUND;
                    n_res.data     = '0;
                    n_res.position = '0;
                    n_state        = ST_IDLE;
                end else begin
                    bus.adv = 1'b1;
                    n_idx   = (r_idx == last_idx) ? '0 : IW'(r_idx + 1'b1);
                    n_cnt   = CW'(r_cnt + 1'b1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= cap_eff)
        else $error("occupancy above capacity");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == '0) |-> (r_head == r_tail))
        else $error("empty queue with head and tail apart");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> $onehot(tok_fwd | tok_wrap))
        else $error("search token not one-hot");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> (r_cnt < r_occ))
        else $error("search walked past the tail");

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !(i_req.action == ACT_SEARCH && r_occ != '0)) |=> o_res_valid)
        else $error("single-cycle request gave no result");
`endif

endmodule

`default_nettype wire
